[rtl/pidis_pkg.sv]
// Package for the PID step with integral separation.
// Holds field widths, register indexes, limits and the gain struct.
// Used by pidis_cfg, pidis_datapath and pid_integral_separation.
package pidis_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ErrW    = SampleW + 1;
  localparam int unsigned IntegW  = 24;
  localparam int unsigned DriveW  = 32;
  localparam int unsigned ProdPW  = GainW + ErrW;
  localparam int unsigned ProdIW  = GainW + IntegW;
  localparam int unsigned AccW    = ProdIW + 2;
  localparam int unsigned FracW   = 8;
  localparam int unsigned ShW     = AccW - FracW;

  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [1:0] RegGainProp  = 2'd0;
  localparam logic [1:0] RegGainInteg = 2'd1;
  localparam logic [1:0] RegGainDeriv = 2'd2;
  localparam logic [1:0] RegSepLimit  = 2'd3;

  localparam logic signed [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
  localparam logic signed [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};
  localparam logic signed [DriveW-1:0] DriveMax = {1'b0, {(DriveW-1){1'b1}}};
  localparam logic signed [DriveW-1:0] DriveMin = {1'b1, {(DriveW-1){1'b0}}};

  typedef struct packed {
    logic signed [GainW-1:0]   gain_prop;
    logic signed [GainW-1:0]   gain_integ;
    logic signed [GainW-1:0]   gain_deriv;
    logic        [SampleW-1:0] separation_limit;
  } gains_t;

endpackage

[rtl/pidis_cfg.sv]
// APB register file for the PID gains and the separation limit.
// Depends on pidis_pkg for the register indexes and the gains_t struct.
module pidis_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pidis_pkg::ApbAddrW-1:0] paddr,
  input  logic [pidis_pkg::ApbDataW-1:0] pwdata,
  output logic [pidis_pkg::ApbDataW-1:0] prdata,
  output logic                           pready,
  output pidis_pkg::gains_t              gains_o
);

  pidis_pkg::gains_t gains_q, gains_d;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign gains_o = gains_q;

  always_comb begin
    gains_d = gains_q;
    if (wr_en) begin
      case (reg_idx)
        pidis_pkg::RegGainProp:  gains_d.gain_prop        = pwdata[15:0];
        pidis_pkg::RegGainInteg: gains_d.gain_integ       = pwdata[15:0];
        pidis_pkg::RegGainDeriv: gains_d.gain_deriv       = pwdata[15:0];
        pidis_pkg::RegSepLimit:  gains_d.separation_limit = pwdata[15:0];
        default: gains_d = gains_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pidis_pkg::RegGainProp:  prdata = {16'h0, gains_q.gain_prop};
      pidis_pkg::RegGainInteg: prdata = {16'h0, gains_q.gain_integ};
      pidis_pkg::RegGainDeriv: prdata = {16'h0, gains_q.gain_deriv};
      pidis_pkg::RegSepLimit:  prdata = {16'h0, gains_q.separation_limit};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else begin
      gains_q <= gains_d;
    end
  end

endmodule

[rtl/pidis_datapath.sv]
// Four-stage PID datapath: input word, error and integral, products, drive.
// Depends on pidis_pkg; gains come from pidis_cfg.
module pidis_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pidis_pkg::gains_t                    gains_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [pidis_pkg::SampleW-1:0] target_value_i,
  input  logic signed [pidis_pkg::SampleW-1:0] sensed_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pidis_pkg::DriveW-1:0]  drive_value_o,
  output logic                                 drive_clipped_o
);

  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;
  logic adv0, adv1, adv2;

  logic signed [pidis_pkg::SampleW-1:0] target_q, sensed_q;
  logic signed [pidis_pkg::SampleW-1:0] prior_q, prior_d;
  logic signed [pidis_pkg::IntegW-1:0]  integ_state_q, integ_state_d;

  logic signed [pidis_pkg::ErrW-1:0]    err;
  logic        [pidis_pkg::ErrW-1:0]    mag;
  logic signed [pidis_pkg::ErrW-1:0]    deriv;
  logic signed [pidis_pkg::IntegW:0]    integ_sum;
  logic                                 separate;

  logic signed [pidis_pkg::ErrW-1:0]    err_q, deriv_q;
  logic signed [pidis_pkg::IntegW-1:0]  integ_q;

  logic signed [pidis_pkg::ProdPW-1:0]  prod_p_q, prod_d_q;
  logic signed [pidis_pkg::ProdIW-1:0]  prod_i_q;

  logic signed [pidis_pkg::AccW-1:0]    acc;
  logic signed [pidis_pkg::ShW-1:0]     shifted;
  logic signed [pidis_pkg::DriveW-1:0]  drive_d, drive_q;
  logic                                 clip_d, clip_q;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign adv0 = v0_q && rdy1;
  assign adv1 = v1_q && rdy2;
  assign adv2 = v2_q && rdy3;

  assign in_ready_o      = rdy0;
  assign out_valid_o     = v3_q;
  assign drive_value_o   = drive_q;
  assign drive_clipped_o = clip_q;

  // error, derivative on measurement, separated integral
  always_comb begin
    err       = pidis_pkg::ErrW'(target_q) - pidis_pkg::ErrW'(sensed_q);
    mag       = err[pidis_pkg::ErrW-1] ? -err : err;
    deriv     = pidis_pkg::ErrW'(sensed_q) - pidis_pkg::ErrW'(prior_q);
    separate  = mag > {1'b0, gains_i.separation_limit};
    integ_sum = (pidis_pkg::IntegW+1)'(integ_state_q) + (pidis_pkg::IntegW+1)'(err);
    if (separate) begin
      integ_state_d = '0;
    end else if (integ_sum > (pidis_pkg::IntegW+1)'(pidis_pkg::IntegMax)) begin
      integ_state_d = pidis_pkg::IntegMax;
    end else if (integ_sum < (pidis_pkg::IntegW+1)'(pidis_pkg::IntegMin)) begin
      integ_state_d = pidis_pkg::IntegMin;
    end else begin
      integ_state_d = integ_sum[pidis_pkg::IntegW-1:0];
    end
    prior_d = sensed_q;
  end

  // sum of terms, floor shift, clamp to drive width
  always_comb begin
    acc     = pidis_pkg::AccW'(prod_p_q) + pidis_pkg::AccW'(prod_i_q)
            - pidis_pkg::AccW'(prod_d_q);
    shifted = acc[pidis_pkg::AccW-1:pidis_pkg::FracW];
    clip_d  = 1'b0;
    drive_d = shifted[pidis_pkg::DriveW-1:0];
    if (shifted > pidis_pkg::ShW'(pidis_pkg::DriveMax)) begin
      drive_d = pidis_pkg::DriveMax;
      clip_d  = 1'b1;
    end else if (shifted < pidis_pkg::ShW'(pidis_pkg::DriveMin)) begin
      drive_d = pidis_pkg::DriveMin;
      clip_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q          <= 1'b0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
      prior_q       <= '0;
      integ_state_q <= '0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (adv0) begin
        prior_q       <= prior_d;
        integ_state_q <= integ_state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      target_q <= target_value_i;
      sensed_q <= sensed_value_i;
    end
    if (adv0) begin
      err_q   <= err;
      deriv_q <= deriv;
      integ_q <= integ_state_d;
    end
    if (adv1) begin
      prod_p_q <= gains_i.gain_prop * err_q;
      prod_i_q <= gains_i.gain_integ * integ_q;
      prod_d_q <= gains_i.gain_deriv * deriv_q;
    end
    if (adv2) begin
      drive_q <= drive_d;
      clip_q  <= clip_d;
    end
  end

`ifndef ASSERT_OFF
  a_clip_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && clip_q) |-> (drive_q == pidis_pkg::DriveMax || drive_q == pidis_pkg::DriveMin))
    else $error("clipped drive not at a bound");

  a_separate_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv0 && separate) |=> (integ_state_q == '0))
    else $error("integral not cleared on large error");

  a_prior_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv0 |=> (prior_q == $past(sensed_q)))
    else $error("previous measurement not updated");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv0 |=> ($stable(prior_q) && $stable(integ_state_q)))
    else $error("state moved without an item");
`endif

endmodule

[rtl/pid_integral_separation.sv]
// Top level of the positional PID step with integral separation.
// Depends on pidis_pkg, pidis_cfg and pidis_datapath.
//
// Each input word carries a setpoint and a measurement. One result word with the
// saturated drive and a clip flag is presented for each input word, which passes
// through a four-register pipeline (input, error/integral, three products, drive).
// A new word is accepted every cycle as long as results are taken; the integral
// and the previous measurement update as a word moves into the second stage, one word
// per cycle. Gains and the separation limit must be written over APB only while the
// block is idle; the block itself does not enforce this.
module pid_integral_separation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pidis_pkg::ApbAddrW-1:0] paddr,
  input  logic [pidis_pkg::ApbDataW-1:0] pwdata,
  output logic [pidis_pkg::ApbDataW-1:0] prdata,
  output logic                           pready,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // target_value, sensed_value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // drive_value
  output logic                           m_axis_tuser   // drive_clipped
);

  pidis_pkg::gains_t gains;

  pidis_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains_o (gains)
  );

  pidis_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .gains_i         (gains),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .target_value_i  (s_axis_tdata[15:0]),
    .sensed_value_i  (s_axis_tdata[31:16]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .drive_value_o   (m_axis_tdata),
    .drive_clipped_o (m_axis_tuser)
  );

endmodule

[test/testbench.sv]
// Self-checking testbench for pid_integral_separation. Depends on pidis_pkg
// and the RTL. Drives samples over the stream ports and gains over APB, and
// checks every result word against an in-bench PID predictor or a typed drive.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pidis_pkg::*;

  localparam int StallLimit = 2000;

  typedef struct {
    logic signed [DriveW-1:0] drive;
    logic                     clip;
  } drive_word_t;

  typedef enum int {MODE_NOISE, MODE_TRACK, MODE_WIND_UP, MODE_WIND_DOWN} walk_mode_e;

  typedef struct {
    bit                        load;
    logic signed [GainW-1:0]   kp;
    logic signed [GainW-1:0]   ki;
    logic signed [GainW-1:0]   kd;
    logic        [SampleW-1:0] lim;
    logic signed [SampleW-1:0] tgt;
    logic signed [SampleW-1:0] sns;
    bit                        typed;
    logic signed [DriveW-1:0]  drive;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;   // target_value, sensed_value
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [31:0]         m_axis_tdata;   // drive_value
  logic                m_axis_tuser;   // drive_clipped

  pid_integral_separation DUT (.*);

  // predictor configuration and state
  logic signed [GainW-1:0]   gain_p = '0;
  logic signed [GainW-1:0]   gain_i = '0;
  logic signed [GainW-1:0]   gain_d = '0;
  logic        [SampleW-1:0] sep_limit = '0;
  logic signed [IntegW-1:0]  integ_sum = '0;
  logic signed [SampleW-1:0] prev_sensed = '0;

  logic [1:0] cfg_index [4] = '{RegGainProp, RegGainInteg, RegGainDeriv, RegSepLimit};
  string      cfg_name  [4] = '{"gain_prop", "gain_integ", "gain_deriv", "separation_limit"};

  drive_word_t drive_expect_q [$];
  plan_row_t   plan [22];
  int          fail_count   = 0;
  int          stall_cycles = 0;
  bit          tx_idle      = 1'b1;
  bit          rx_idle      = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic drive_word_t predict_drive(logic signed [SampleW-1:0] tgt,
                                                logic signed [SampleW-1:0] sns);
    logic signed [ErrW-1:0] err;
    logic signed [ErrW-1:0] dlt;
    logic        [ErrW-1:0] mag;
    logic signed [IntegW:0] sum;
    logic signed [63:0]     acc;
    drive_word_t            w;
    err = tgt - sns;
    mag = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
    if (mag > ErrW'(sep_limit)) begin
      integ_sum = '0;
    end else begin
      sum = integ_sum + err;
      if (sum > IntegMax) integ_sum = IntegMax;
      else if (sum < IntegMin) integ_sum = IntegMin;
      else integ_sum = sum[IntegW-1:0];
    end
    dlt = sns - prev_sensed;
    prev_sensed = sns;
    acc = gain_p * err + gain_i * integ_sum - gain_d * dlt;
    acc = acc >>> FracW;
    w.clip = 1'b1;
    if (acc > DriveMax) begin
      w.drive = DriveMax;
    end else if (acc < DriveMin) begin
      w.drive = DriveMin;
    end else begin
      w.drive = acc[DriveW-1:0];
      w.clip  = 1'b0;
    end
    return w;
  endfunction

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic logic signed [GainW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return 16'sd256;
      4: return 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [SampleW-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [15:0] v,
                            output logic [ApbDataW-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= {{16{v[15]}}, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
  endtask

  task automatic check_regs();
    logic [15:0]         want [4];
    logic [ApbDataW-1:0] rd;
    want = '{gain_p, gain_i, gain_d, sep_limit};
    for (int r = 0; r < 4; r++) begin
      apb_access(1'b0, cfg_index[r], '0, rd);
      if (rd[15:0] !== want[r]) begin
        $error("%s readback expected %0h actual %0h", cfg_name[r], want[r], rd[15:0]);
        fail_count++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_gains(logic signed [GainW-1:0] kp, logic signed [GainW-1:0] ki,
                            logic signed [GainW-1:0] kd, logic [SampleW-1:0] lim);
    logic [15:0]         vals [4];
    logic [ApbDataW-1:0] rd;
    vals = '{kp, ki, kd, lim};
    for (int r = 0; r < 4; r++) apb_access(1'b1, cfg_index[r], vals[r], rd);
    gain_p    = kp;
    gain_i    = ki;
    gain_d    = kd;
    sep_limit = lim;
    check_regs();
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [SampleW-1:0] tgt, logic signed [SampleW-1:0] sns,
                             bit typed, logic signed [DriveW-1:0] drive);
    int          gap;
    drive_word_t w;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sns, tgt};
    do @(posedge clk_i); while (!s_axis_tready);
    w = predict_drive(tgt, sns);
    if (typed) begin
      w.drive = drive;
      w.clip  = 1'b0;
    end
    drive_expect_q.push_back(w);
  endtask

  // result sink and checker
  initial begin
    int          gap;
    drive_word_t w;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = rx_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      if (drive_expect_q.size() == 0) begin
        $error("result word with no expectation: drive_value %0d", $signed(m_axis_tdata));
        fail_count++;
      end else begin
        w = drive_expect_q.pop_front();
        if (m_axis_tdata !== w.drive) begin
          $error("drive_value expected %0d actual %0d", w.drive, $signed(m_axis_tdata));
          fail_count++;
        end
        if (m_axis_tuser !== w.clip) begin
          $error("drive_clipped expected %0b actual %0b", w.clip, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int                        sent;
    int                        len;
    int                        base;
    int                        t;
    int                        s;
    int                        spread;
    walk_mode_e                mode;
    logic signed [GainW-1:0]   kp;
    logic signed [GainW-1:0]   ki;
    logic signed [GainW-1:0]   kd;
    logic        [SampleW-1:0] lim;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    plan = '{
      '{1,      0,     0,    256,     16'd0,  32767, -32768, 1,  32768},
      '{0,      0,     0,      0,     16'd0,      0,  32767, 1, -65535},
      '{0,      0,     0,      0,     16'd0,      0, -32768, 1,  65535},
      '{1,    256,     0,      0,     16'd0,  32767, -32768, 1,  65535},
      '{0,      0,     0,      0,     16'd0, -32768,  32767, 1, -65535},
      '{0,      0,     0,      0,     16'd0,      0,      0, 1,      0},
      '{1,      0,   256,      0,   16'd100,    100,      0, 1,    100},
      '{0,      0,     0,      0,     16'd0,     -1,    100, 1,      0},
      '{0,      0,     0,      0,     16'd0,      0,    100, 1,   -100},
      '{0,      0,     0,      0,     16'd0,     50,    100, 1,   -150},
      '{0,      0,     0,      0,     16'd0,    101,      0, 1,      0},
      '{1, -32768, 32767, -32768, 16'd65535,  32767, -32768, 0,      0},
      '{0,      0,     0,      0,     16'd0, -32768,  32767, 0,      0},
      '{0,      0,     0,      0,     16'd0,  32767,  32767, 0,      0},
      '{0,      0,     0,      0,     16'd0, -32768, -32768, 0,      0},
      '{1,  32767, -32768, 32767, 16'd65534,  32767, -32768, 0,      0},
      '{0,      0,     0,      0,     16'd0, -32768,  32767, 0,      0},
      '{0,      0,     0,      0,     16'd0,  21845, -21846, 0,      0},
      '{0,      0,     0,      0,     16'd0, -21846,  21845, 0,      0},
      '{1,      1,     0,      0,     16'd0,     -1,      0, 1,     -1},
      '{0,      0,     0,      0,     16'd0,      1,      0, 1,      0},
      '{1,     -1,     0,      0,     16'd0,      1,      0, 1,     -1}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    foreach (plan[i]) begin
      if (plan[i].load) begin
        wait_idle();
        load_gains(plan[i].kp, plan[i].ki, plan[i].kd, plan[i].lim);
      end
      send_sample(plan[i].tgt, plan[i].sns, plan[i].typed, plan[i].drive);
    end

    sent = 0;
    while (sent < 1900) begin
      case ($urandom_range(0, 9))
        0, 1, 2: mode = MODE_NOISE;
        7:       mode = MODE_WIND_UP;
        8:       mode = MODE_WIND_DOWN;
        default: mode = MODE_TRACK;
      endcase
      kp  = pick_gain();
      ki  = pick_gain();
      kd  = pick_gain();
      lim = pick_limit();
      if (mode == MODE_WIND_UP || mode == MODE_WIND_DOWN) begin
        lim = 16'hffff;
        len = $urandom_range(150, 350);
      end else begin
        len = $urandom_range(10, 200);
      end
      if (len > 1900 - sent) len = 1900 - sent;
      wait_idle();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      load_gains(kp, ki, kd, lim);
      base   = int'($signed(16'($urandom)));
      spread = $urandom_range(4, 400);
      repeat (len) begin
        case (mode)
          MODE_NOISE: begin
            t = int'($signed(16'($urandom)));
            s = int'($signed(16'($urandom)));
          end
          MODE_WIND_UP: begin
            t = $urandom_range(0, 32767);
            s = -int'($urandom_range(0, 32768));
          end
          MODE_WIND_DOWN: begin
            t = -int'($urandom_range(0, 32768));
            s = $urandom_range(0, 32767);
          end
          default: begin
            base = clamp16(base + int'($urandom_range(0, 64)) - 32);
            t    = base;
            s    = clamp16(t - (int'($urandom_range(0, 2 * spread)) - spread));
          end
        endcase
        send_sample(16'(t), 16'(s), 1'b0, '0);
      end
      sent += len;
    end

    wait_idle();
    if (fail_count == 0 && drive_expect_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[pid_integral_separation.f]
rtl/pidis_pkg.sv
rtl/pidis_cfg.sv
rtl/pidis_datapath.sv
rtl/pid_integral_separation.sv
test/testbench.sv
